// ----- src/klpg_pkg.sv -----
// ----------------------------------------------------------------------------
// klpg_pkg
// Shared types and register indexes for the rank-1 lattice point generator.
// ----------------------------------------------------------------------------
package klpg_pkg;

	localparam int DIM_W     = 3;
	localparam int CFG_IDX_W = 3;

	typedef logic [DIM_W-1:0]     dim_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_NUM_POINTS = 3'd0;
	localparam cfg_idx_t REG_DIM_COUNT  = 3'd1;
	localparam cfg_idx_t REG_GEN_BASE   = 3'd2;

endpackage

// ----- src/korobov_lattice_point_generator_top.sv -----
// ----------------------------------------------------------------------------
// korobov_lattice_point_generator_top: rank-1 lattice point generator
// Words for a taken request come one per dimension from the one-bit-per-cycle divider;
// the next request is taken only after every word is loaded and all MAX_DIM numerators
// advance (the advance stops early on the last point); output stalls add delay.
// Reset restores n = 1, one dimension, g0 = 1, other generators 0, point 0.
// ----------------------------------------------------------------------------
module korobov_lattice_point_generator_top import klpg_pkg::*; #(
	parameter int MAX_DIM    = 6,
	parameter int COUNT_BITS = 20,
	parameter int FRAC_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_idx_t              cfg_index,
	input  logic [COUNT_BITS:0]   cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COUNT_BITS-1:0] point_index,
	output dim_t                  dim_index,
	output logic [COUNT_BITS-1:0] coord_num,
	output logic [FRAC_BITS-1:0]  coord_frac,
	output logic                  last_dim,
	output logic                  last_point,
	output logic                  bad_generator
);

	localparam int CB = COUNT_BITS;

	logic [CB:0]                      num_points_q;
	dim_t                             dim_count_q;
	logic [MAX_DIM-1:0][CB-1:0]       gen_q;
	logic [CB:0]                      n_eff;
	dim_t                             dims_eff;
	logic                             cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		if (num_points_q == '0) begin
			n_eff = (CB+1)'(1);
		end else if (num_points_q > ((CB+1)'(1) << CB)) begin
			n_eff = (CB+1)'(1) << CB;
		end else begin
			n_eff = num_points_q;
		end
		if (dim_count_q == '0) begin
			dims_eff = DIM_W'(1);
		end else if (dim_count_q > DIM_W'(MAX_DIM)) begin
			dims_eff = DIM_W'(MAX_DIM);
		end else begin
			dims_eff = dim_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q <= (CB+1)'(1);
			dim_count_q  <= DIM_W'(1);
			for (int g = 0; g < MAX_DIM; g++) begin
				gen_q[g] <= (g == 0) ? CB'(1) : '0;
			end
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_NUM_POINTS: num_points_q <= cfg_data;
				REG_DIM_COUNT:  dim_count_q  <= cfg_data[DIM_W-1:0];
				default: begin
					for (int g = 0; g < MAX_DIM; g++) begin
						if (cfg_index == CFG_IDX_W'(int'(REG_GEN_BASE) + g)) begin
							gen_q[g] <= cfg_data[CB-1:0];
						end
					end
				end
			endcase
		end
	end

	klpg_core #(
		.MAX_DIM   (MAX_DIM),
		.COUNT_BITS(COUNT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_clear    (cfg_wr),
		.n_eff        (n_eff),
		.dims_eff     (dims_eff),
		.gens         (gen_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_index  (point_index),
		.dim_index    (dim_index),
		.coord_num    (coord_num),
		.coord_frac   (coord_frac),
		.last_dim     (last_dim),
		.last_point   (last_point),
		.bad_generator(bad_generator)
	);

`ifndef SYNTHESIS
	a_num_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (({1'b0, coord_num} < n_eff) && ({1'b0, point_index} < n_eff)))
		else $error("numerator or point index not below modulus");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_generator) |-> ((coord_num == '0) && (coord_frac == '0)))
		else $error("bad generator word carries a nonzero coordinate");

	a_last_dim: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_dim) |-> ((dim_index + DIM_W'(1)) == dims_eff))
		else $error("last_dim on a word that is not the final dimension");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while a point is in progress");
`endif

endmodule

// ----- src/klpg_div.sv -----
// ----------------------------------------------------------------------------
// klpg_div
// Restoring divider, one quotient bit per cycle: quot = floor(num*2^QW/den),
// for num < den.
// ----------------------------------------------------------------------------
module klpg_div #(
	parameter int NW = 21,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [NW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quot
);

	localparam int CW = $clog2(QW + 1);

	logic [NW-1:0] rem_q;
	logic [QW-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [NW:0] shifted;
	logic [NW:0] diff;
	logic        ge;

	assign shifted = {rem_q, 1'b0};
	assign ge      = shifted >= {1'b0, den};
	assign diff    = shifted - {1'b0, den};
	assign done    = !busy_q;
	assign quot    = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			rem_q  <= num;
			quot_q <= '0;
			cnt_q  <= CW'(QW);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[NW-1:0] : shifted[NW-1:0];
			quot_q <= {quot_q[QW-2:0], ge};
			cnt_q  <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/klpg_core.sv -----
// ----------------------------------------------------------------------------
// klpg_core
// Point sequencer: numerator store, modular advance, output word register,
// and the shared divider that forms each coordinate fraction.
// ----------------------------------------------------------------------------
module klpg_core import klpg_pkg::*; #(
	parameter int MAX_DIM    = 6,
	parameter int COUNT_BITS = 20,
	parameter int FRAC_BITS  = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_clear,
	input  logic [COUNT_BITS:0]                  n_eff,
	input  dim_t                                 dims_eff,
	input  logic [MAX_DIM-1:0][COUNT_BITS-1:0]   gens,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [COUNT_BITS-1:0]                point_index,
	output dim_t                                 dim_index,
	output logic [COUNT_BITS-1:0]                coord_num,
	output logic [FRAC_BITS-1:0]                 coord_frac,
	output logic                                 last_dim,
	output logic                                 last_point,
	output logic                                 bad_generator
);

	localparam int CB    = COUNT_BITS;
	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_ADV
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic [CB-1:0]    cnt_q;
	logic [CB-1:0]    nums_q [MAX_DIM];
	logic             out_valid_q;

	logic [CB-1:0]        gen_sel;
	logic [CB-1:0]        num_sel;
	logic                 bad_sel;
	logic [CB:0]          sum;
	logic [CB-1:0]        nxt_num;
	logic                 is_last_pt;
	logic                 is_last_dim;
	logic                 out_free;
	logic                 load_out;
	logic                 clr_walk;
	logic                 div_start;
	logic                 div_done;
	logic [CB-1:0]        div_num;
	logic [FRAC_BITS-1:0] div_quot;

	assign gen_sel     = gens[idx_q];
	assign num_sel     = nums_q[idx_q];
	assign bad_sel     = {1'b0, gen_sel} >= n_eff;
	assign sum         = {1'b0, num_sel} + {1'b0, gen_sel};
	assign nxt_num     = (sum >= n_eff) ? CB'(sum - n_eff) : sum[CB-1:0];
	assign is_last_pt  = ({1'b0, cnt_q} + (CB+1)'(1)) == n_eff;
	assign is_last_dim = (DIM_W'(idx_q) + DIM_W'(1)) == dims_eff;
	assign out_free    = !out_valid_q || out_ready;
	assign load_out    = (state_q == ST_WAIT) && div_done && out_free;
	assign clr_walk    = cfg_clear
		|| ((state_q == ST_IDLE) && in_valid && (restart || ({1'b0, cnt_q} >= n_eff)))
		|| ((state_q == ST_ADV) && is_last_pt);
	assign div_start   = state_q == ST_START;
	assign div_num     = bad_sel ? '0 : num_sel;
	assign in_ready    = state_q == ST_IDLE;
	assign out_valid   = out_valid_q;

	klpg_div #(
		.NW(CB + 1),
		.QW(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ({1'b0, div_num}),
		.den   (n_eff),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < MAX_DIM; k++) begin
				nums_q[k] <= '0;
			end
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (clr_walk) begin
				cnt_q <= '0;
				for (int k = 0; k < MAX_DIM; k++) begin
					nums_q[k] <= '0;
				end
			end else if (state_q == ST_ADV) begin
				nums_q[idx_q] <= bad_sel ? '0 : nxt_num;
				if (idx_q == IDX_W'(MAX_DIM - 1)) begin
					cnt_q <= cnt_q + CB'(1);
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (load_out) begin
						point_index   <= cnt_q;
						dim_index     <= DIM_W'(idx_q);
						coord_num     <= div_num;
						coord_frac    <= div_quot;
						last_dim      <= is_last_dim;
						last_point    <= is_last_pt;
						bad_generator <= bad_sel;
						if (is_last_dim) begin
							idx_q   <= '0;
							state_q <= ST_ADV;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_START;
						end
					end
				end
				ST_ADV: begin
					if (is_last_pt || (idx_q == IDX_W'(MAX_DIM - 1))) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
